### rtl/acpu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpu_pkg
// types and constants shared by the accumulator processor core
// ----------------------------------------------------------------------------
package acpu_pkg;

  localparam int DATA_W = 16;
  localparam int ADDR_W = 12;

  // instruction opcodes, bits 15..12 of an instruction word
  typedef enum logic [3:0] {
    OP_HALT    = 4'h0,
    OP_LOAD    = 4'h1,
    OP_LOAD_MQ = 4'h2,
    OP_LDMQ    = 4'h3,
    OP_STOR    = 4'h4,
    OP_STA     = 4'h5,
    OP_ADD     = 4'h6,
    OP_SUB     = 4'h7,
    OP_MUL     = 4'h8,
    OP_DIV     = 4'h9,
    OP_JMP     = 4'hA,
    OP_JZ      = 4'hB,
    OP_JNZ     = 4'hC,
    OP_JGE     = 4'hD,
    OP_IN      = 4'hE,
    OP_OUT     = 4'hF
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_LOADED   = 2'd0,
    STAT_EXECUTED = 2'd1,
    STAT_HALTED   = 2'd2
  } status_t;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_EXEC = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_EXEC,
    S_DIV,
    S_RESULT
  } state_t;

  // request payload, last field in the lowest bits
  typedef struct packed {
    logic [3:0]        pad;
    logic [DATA_W-1:0] in_value;
    logic [DATA_W-1:0] load_data;
    logic [ADDR_W-1:0] load_address;
  } in_data_t;

  // result payload, last field in the lowest bits
  typedef struct packed {
    logic [3:0]        pad;
    logic [ADDR_W-1:0] operand_address;
    logic [DATA_W-1:0] buffer_value;
    logic [DATA_W-1:0] mq_value;
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] instr_word;
    logic [ADDR_W-1:0] next_pc;
    logic [ADDR_W-1:0] instr_pc;
  } out_data_t;

  typedef struct packed {
    logic    in_taken;
    logic    out_valid;
    status_t status;
  } out_user_t;

endpackage

### rtl/acpu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpu_div
// 16-bit signed truncating divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module acpu_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quotient,
  output logic [15:0] remainder
);

  logic        busy;
  logic [3:0]  cnt;
  logic [16:0] rem;
  logic [15:0] quo;
  logic [15:0] dv;
  logic        neg_q;
  logic        neg_r;
  logic [16:0] rem_sh;
  logic [16:0] rem_sub;

  assign rem_sh  = {rem[15:0], quo[15]};
  assign rem_sub = rem_sh - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        // magnitudes; 0x8000 stays valid as an unsigned magnitude
        quo   <= dividend[15] ? 16'(-dividend) : dividend;
        dv    <= divisor[15] ? 16'(-divisor) : divisor;
        neg_q <= dividend[15] ^ divisor[15];
        neg_r <= dividend[15];
      end else if (busy) begin
        if (!rem_sub[16]) begin
          rem <= rem_sub;
          quo <= {quo[14:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[14:0], 1'b0};
        end
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // sign fix: quotient by sign difference, remainder follows the dividend
  assign quotient  = neg_q ? 16'(-quo) : quo;
  assign remainder = neg_r ? 16'(-rem[15:0]) : rem[15:0];

endmodule

### rtl/accumulator_cpu_16bit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_cpu_16bit_core
// 16-bit accumulator processor; unless halted, each request loads a word or runs one instruction
// ----------------------------------------------------------------------------
//  channel  | direction | tdata                              | tuser
//  s_axis   | in        | load_address, load_data, in_value  | opcode (0 load, 1 exec)
//  m_axis   | out       | instr_pc .. operand_address        | status, out_valid, in_taken
//
//  a word load or a step while halted goes through accept and result, an instruction
//  through accept, fetch read, operand read / write-back and result, as the word memory
//  has a registered read port; a divide by a nonzero word waits on the divider first
//  after reset the memory is cleared one word a cycle, all MEM_WORDS words, with
//  s_axis_tready low
//  a new request is accepted while the previous result waits on m_axis
// ----------------------------------------------------------------------------
module accumulator_cpu_16bit_core #(
  parameter int MEM_WORDS = 4096
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,   // load_address[11:0], load_data[27:12], in_value[43:28]
  input  logic         s_axis_tuser,   // opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // instr_pc, next_pc, instr_word, acc, mq_value,
                                       // buffer_value, operand_address
  output logic [3:0]   m_axis_tuser    // status[1:0], out_valid, in_taken
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_WORDS - 1);

  // 12-bit address modulo MEM_WORDS; the value is below four times the depth
  function automatic logic [AW-1:0] mem_idx(input logic [11:0] a);
    logic [12:0] v;
    v = {1'b0, a};
    for (int i = 0; i < 3; i++) begin
      if (v >= 13'(MEM_WORDS)) v = v - 13'(MEM_WORDS);
    end
    return v[AW-1:0];
  endfunction

  acpu_pkg::state_t   state, state_next;
  acpu_pkg::in_data_t req;
  acpu_pkg::opcode_t  op;

  // word memory
  logic [15:0]   mem [MEM_WORDS];
  logic [15:0]   mem_rd;
  logic [AW-1:0] mem_raddr;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_we;
  logic [AW-1:0] clr_addr;

  // architectural registers
  logic [11:0] pc;
  logic [15:0] acc;
  logic [15:0] mq;
  logic [15:0] mbr;
  logic        halted;

  // per-request context
  logic [15:0] ir;
  logic [11:0] ipc;
  logic [15:0] in_val;
  acpu_pkg::status_t res_status;
  logic        res_exec;

  logic        div_start;
  logic        div_done;
  logic [15:0] div_quo;
  logic [15:0] div_rem;
  logic        out_load;
  logic signed [31:0] prod;

  acpu_pkg::out_data_t out_d;
  acpu_pkg::out_user_t out_u;

  assign req  = acpu_pkg::in_data_t'(s_axis_tdata);
  assign op   = acpu_pkg::opcode_t'(ir[15:12]);
  assign prod = $signed(mq) * $signed(mem_rd);

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rd <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= acpu_pkg::S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == acpu_pkg::S_CLEAR) clr_addr <= clr_addr + AW'(1);
    end
  end

  // next state, memory port control and handshakes
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = mem_idx(ir[11:0]);
    mem_wdata     = acc;
    mem_raddr     = mem_idx(pc);
    div_start     = 1'b0;
    out_load      = 1'b0;
    case (state)
      acpu_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == LAST_ADDR) state_next = acpu_pkg::S_IDLE;
      end
      acpu_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (halted) begin
            state_next = acpu_pkg::S_RESULT;
          end else if (acpu_pkg::kind_t'(s_axis_tuser) == acpu_pkg::KIND_LOAD) begin
            // word load goes straight into memory
            mem_we     = 1'b1;
            mem_waddr  = mem_idx(req.load_address);
            mem_wdata  = req.load_data;
            state_next = acpu_pkg::S_RESULT;
          end else begin
            state_next = acpu_pkg::S_FETCH;
          end
        end
      end
      acpu_pkg::S_FETCH: begin
        // instruction word on mem_rd, read the operand at its address field
        mem_raddr  = mem_idx(mem_rd[11:0]);
        state_next = acpu_pkg::S_EXEC;
      end
      acpu_pkg::S_EXEC: begin
        state_next = acpu_pkg::S_RESULT;
        case (op)
          acpu_pkg::OP_STOR: mem_we = 1'b1;
          acpu_pkg::OP_STA: begin
            // replace only the address field of the stored word
            mem_we    = 1'b1;
            mem_wdata = {mem_rd[15:12], acc[11:0]};
          end
          acpu_pkg::OP_DIV: begin
            if (mem_rd != 16'd0) begin
              div_start  = 1'b1;
              state_next = acpu_pkg::S_DIV;
            end
          end
          default: ;
        endcase
      end
      acpu_pkg::S_DIV: begin
        if (div_done) state_next = acpu_pkg::S_RESULT;
      end
      acpu_pkg::S_RESULT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = acpu_pkg::S_IDLE;
        end
      end
      default: state_next = acpu_pkg::S_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= '0;
      acc        <= '0;
      mq         <= '0;
      mbr        <= '0;
      halted     <= 1'b0;
      res_exec   <= 1'b0;
      res_status <= acpu_pkg::STAT_LOADED;
    end else begin
      case (state)
        acpu_pkg::S_IDLE: begin
          if (s_axis_tvalid) begin
            in_val   <= req.in_value;
            res_exec <= 1'b0;
            if (halted) begin
              res_status <= acpu_pkg::STAT_HALTED;
            end else if (acpu_pkg::kind_t'(s_axis_tuser) == acpu_pkg::KIND_LOAD) begin
              res_status <= acpu_pkg::STAT_LOADED;
            end else begin
              res_status <= acpu_pkg::STAT_EXECUTED;
              res_exec   <= 1'b1;
            end
          end
        end
        acpu_pkg::S_FETCH: begin
          ir  <= mem_rd;
          mbr <= mem_rd;
          ipc <= pc;
          pc  <= pc + 12'd1;
        end
        acpu_pkg::S_EXEC: begin
          case (op)
            acpu_pkg::OP_HALT: halted <= 1'b1;
            acpu_pkg::OP_LOAD: begin
              mbr <= mem_rd;
              acc <= mem_rd;
            end
            acpu_pkg::OP_LOAD_MQ: acc <= mq;
            acpu_pkg::OP_LDMQ: begin
              mbr <= mem_rd;
              mq  <= mem_rd;
            end
            acpu_pkg::OP_STOR: mbr <= acc;
            acpu_pkg::OP_STA:  mbr <= acc;
            acpu_pkg::OP_ADD: begin
              mbr <= mem_rd;
              acc <= acc + mem_rd;
            end
            acpu_pkg::OP_SUB: begin
              mbr <= mem_rd;
              acc <= acc - mem_rd;
            end
            acpu_pkg::OP_MUL: begin
              mbr <= mem_rd;
              acc <= prod[31:16];
              mq  <= prod[15:0];
            end
            acpu_pkg::OP_DIV: mbr <= mem_rd;
            acpu_pkg::OP_JMP: pc <= ir[11:0];
            acpu_pkg::OP_JZ:  if (acc == 16'd0) pc <= ir[11:0];
            acpu_pkg::OP_JNZ: if (acc != 16'd0) pc <= ir[11:0];
            acpu_pkg::OP_JGE: if (!acc[15]) pc <= ir[11:0];
            acpu_pkg::OP_IN:  acc <= in_val;
            default: ;
          endcase
        end
        acpu_pkg::S_DIV: begin
          if (div_done) begin
            mq  <= div_quo;
            acc <= div_rem;
          end
        end
        default: ;
      endcase
    end
  end

  acpu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (acc),
    .divisor   (mem_rd),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_d.pad             <= '0;
      out_d.instr_pc        <= res_exec ? ipc : 12'd0;
      out_d.next_pc         <= pc;
      out_d.instr_word      <= res_exec ? ir : 16'd0;
      out_d.acc             <= acc;
      out_d.mq_value        <= mq;
      out_d.buffer_value    <= mbr;
      out_d.operand_address <= res_exec ? ir[11:0] : 12'd0;
      out_u.status          <= res_status;
      out_u.out_valid       <= res_exec && (op == acpu_pkg::OP_OUT);
      out_u.in_taken        <= res_exec && (op == acpu_pkg::OP_IN);
    end
  end

  assign m_axis_tdata = out_d;
  assign m_axis_tuser = out_u;

  // no request taken during the memory clearing pass
  assert property (@(posedge clk) disable iff (rst)
    (state == acpu_pkg::S_CLEAR) |-> !s_axis_tready)
    else $error("request accepted while clearing memory");

  // divider finishes only while the sequencer waits on it
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == acpu_pkg::S_DIV))
    else $error("divider done outside divide wait");

  // halt is sticky until reset
  assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halted flag dropped");

  // memory is written only when clearing, loading or storing
  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == acpu_pkg::S_CLEAR || state == acpu_pkg::S_IDLE ||
                state == acpu_pkg::S_EXEC))
    else $error("unexpected memory write");

  // a result is loaded only when the output register is free
  assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten before it was taken");

endmodule
